/* design/cgf_pkg.sv */
// Shared types and constants for the camera ground footprint pipeline.
// Depends on nothing; imported by every module of the block.
package cgf_pkg;

    localparam int ALT_W     = 20;   // altitude, meters * 256
    localparam int OUT_W     = 32;   // footprint results
    localparam int CW        = 33;   // CORDIC x / y datapath
    localparam int ZW        = 25;   // CORDIC residual angle, degrees * 2^16
    localparam int ATAN_W    = 23;   // arctangent table entries
    localparam int ATAN_LEN  = 32;   // arctangent table depth
    localparam int DIV_BITS  = 56;   // quotient bits of y * 2^24 / x
    localparam int TAN_W     = 57;   // signed tangent, 24 fraction bits
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HFOV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VFOV = 2'd1;

    localparam logic [15:0] HFOV_RESET = 16'd10138;
    localparam logic [15:0] VFOV_RESET = 16'd6909;

    localparam logic signed [CW-1:0] X_START = 33'sh0_4000_0000;

    typedef struct packed {
        logic valid;
        logic bad;
    } stat_t;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_deg(input logic [4:0] i);
        logic [ATAN_W-1:0] r;
        case (i)
            5'd0:    r = 23'd2949120;
            5'd1:    r = 23'd1740967;
            5'd2:    r = 23'd919879;
            5'd3:    r = 23'd466945;
            5'd4:    r = 23'd234379;
            5'd5:    r = 23'd117304;
            5'd6:    r = 23'd58666;
            5'd7:    r = 23'd29335;
            5'd8:    r = 23'd14668;
            5'd9:    r = 23'd7334;
            5'd10:   r = 23'd3667;
            5'd11:   r = 23'd1833;
            5'd12:   r = 23'd917;
            5'd13:   r = 23'd458;
            5'd14:   r = 23'd229;
            5'd15:   r = 23'd115;
            5'd16:   r = 23'd57;
            5'd17:   r = 23'd29;
            5'd18:   r = 23'd14;
            5'd19:   r = 23'd7;
            5'd20:   r = 23'd4;
            5'd21:   r = 23'd2;
            5'd22:   r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

endpackage

/* design/cgf_cordic.sv */
// Edge angle former and pipelined CORDIC rotation, one iteration per stage.
// Depends on cgf_pkg (widths, arctangent table, stat_t).
module cgf_cordic #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int TAN_ITERATIONS  = 16,
    parameter bit SUM             = 1'b1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic signed [15:0]             tilt,
    input  logic [15:0]                    fov,
    output cgf_pkg::stat_t                 st,
    output logic signed [cgf_pkg::CW-1:0]  x,
    output logic signed [cgf_pkg::CW-1:0]  y
);
    import cgf_pkg::*;

    localparam int NIT = (TAN_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TAN_ITERATIONS;
    localparam int ZL  = (ANGLE_FRAC_BITS + 1 <= 16) ? (16 - ANGLE_FRAC_BITS - 1) : 0;
    localparam int ZR  = (ANGLE_FRAC_BITS + 1 > 16) ? (ANGLE_FRAC_BITS + 1 - 16) : 0;
    localparam logic signed [31:0] LIMIT = 32'(90 * (2 ** (ANGLE_FRAC_BITS + 1)));

    logic signed [31:0] tilt2;
    logic signed [31:0] fov_s;
    logic signed [31:0] e2;
    logic signed [31:0] zf;
    logic               bad_next;

    logic                 v_reg [0:NIT];
    logic                 b_reg [0:NIT];
    logic signed [CW-1:0] x_reg [0:NIT];
    logic signed [CW-1:0] y_reg [0:NIT];
    logic signed [ZW-1:0] z_reg [0:NIT];

    // edge angle with one extra fraction bit, then moved to 16 fraction bits
    always_comb
    begin
        tilt2    = $signed({{15{tilt[15]}}, tilt, 1'b0});
        fov_s    = $signed({16'd0, fov});
        e2       = SUM ? (tilt2 + fov_s) : (tilt2 - fov_s);
        zf       = (e2 <<< ZL) >>> ZR;
        bad_next = (e2 >= LIMIT) || (e2 <= -LIMIT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        b_reg[0] <= bad_next;
        x_reg[0] <= X_START;
        y_reg[0] <= '0;
        z_reg[0] <= zf[ZW-1:0];
    end

    for (genvar i = 0; i < NIT; i++)
    begin : g_iter
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [ZW-1:0] z_next;
        logic signed [ZW-1:0] step;

        always_comb
        begin
            step = $signed({2'b00, atan_deg(5'(i))});
            if (!z_reg[i][ZW-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - step;
            end
            else
            begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + step;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= v_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            b_reg[i+1] <= b_reg[i];
            x_reg[i+1] <= x_next;
            y_reg[i+1] <= y_next;
            z_reg[i+1] <= z_next;
        end
    end

    assign st.valid = v_reg[NIT];
    assign st.bad   = b_reg[NIT];
    assign x        = x_reg[NIT];
    assign y        = y_reg[NIT];

endmodule

/* design/cgf_div.sv */
// Pipelined restoring divider: tan = (y * 2^24) / x, truncated toward zero.
// Depends on cgf_pkg (widths, stat_t). One quotient bit per stage.
module cgf_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cgf_pkg::stat_t                    st_in,
    input  logic signed [cgf_pkg::CW-1:0]     x,
    input  logic signed [cgf_pkg::CW-1:0]     y,
    output cgf_pkg::stat_t                    st_out,
    output logic signed [cgf_pkg::TAN_W-1:0]  tan
);
    import cgf_pkg::*;

    localparam int NB = DIV_BITS;

    logic signed [CW-1:0] ymag;
    logic                 bad_next;

    logic          v_reg  [0:NB];
    logic          b_reg  [0:NB];
    logic          n_reg  [0:NB];
    logic [31:0]   d_reg  [0:NB];
    logic [31:0]   r_reg  [0:NB];
    logic [NB-1:0] q_reg  [0:NB];

    logic                    vo_reg;
    logic                    bo_reg;
    logic signed [TAN_W-1:0] tan_reg;

    always_comb
    begin
        ymag     = y[CW-1] ? -y : y;
        bad_next = st_in.bad || x[CW-1] || (x == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
            vo_reg   <= 1'b0;
        end
        else
        begin
            v_reg[0] <= st_in.valid;
            vo_reg   <= v_reg[NB];
        end
    end

    // hold a divisor of one on a bad lane so the datapath stays defined
    always_ff @(posedge clk)
    begin
        b_reg[0] <= bad_next;
        n_reg[0] <= y[CW-1];
        d_reg[0] <= bad_next ? 32'd1 : x[31:0];
        r_reg[0] <= '0;
        q_reg[0] <= {ymag[31:0], 24'd0};
    end

    for (genvar k = 0; k < NB; k++)
    begin : g_bit
        logic [32:0]   r2;
        logic          ge;
        logic [32:0]   diff;
        logic [31:0]   r_next;
        logic [NB-1:0] q_next;

        always_comb
        begin
            r2     = {r_reg[k], q_reg[k][NB-1]};
            diff   = r2 - {1'b0, d_reg[k]};
            ge     = (r2 >= {1'b0, d_reg[k]});
            r_next = ge ? diff[31:0] : r2[31:0];
            q_next = {q_reg[k][NB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            b_reg[k+1] <= b_reg[k];
            n_reg[k+1] <= n_reg[k];
            d_reg[k+1] <= d_reg[k];
            r_reg[k+1] <= r_next;
            q_reg[k+1] <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bo_reg  <= b_reg[NB];
        tan_reg <= n_reg[NB] ? -$signed({1'b0, q_reg[NB]}) : $signed({1'b0, q_reg[NB]});
    end

    assign st_out.valid = vo_reg;
    assign st_out.bad   = bo_reg;
    assign tan          = tan_reg;

endmodule

/* design/cgf_span.sv */
// One footprint dimension: |tan_a - tan_b| * altitude, rounded and saturated.
// Depends on cgf_pkg (widths, stat_t). Four register stages.
module cgf_span (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cgf_pkg::stat_t                     st_a,
    input  cgf_pkg::stat_t                     st_b,
    input  logic signed [cgf_pkg::TAN_W-1:0]   tan_a,
    input  logic signed [cgf_pkg::TAN_W-1:0]   tan_b,
    input  logic [cgf_pkg::ALT_W-1:0]          alt,
    output logic                               valid,
    output logic [cgf_pkg::OUT_W-1:0]          value,
    output logic                               flag
);
    import cgf_pkg::*;

    localparam int LO_W = 29;
    localparam int HI_W = TAN_W - LO_W;
    localparam int P_W  = ALT_W + TAN_W;

    logic signed [TAN_W:0] dsub;
    logic [TAN_W-1:0]      diff_next;
    logic [P_W:0]          rnd;

    logic                   v1_reg, v2_reg, v3_reg, v4_reg;
    logic                   b1_reg, b2_reg, b3_reg;
    logic [TAN_W-1:0]       diff_reg;
    logic [ALT_W-1:0]       alt_reg;
    logic [ALT_W+LO_W-1:0]  plo_reg;
    logic [ALT_W+HI_W-1:0]  phi_reg;
    logic [P_W-1:0]         prod_reg;
    logic [OUT_W-1:0]       value_reg;
    logic                   flag_reg;

    always_comb
    begin
        dsub      = $signed({tan_a[TAN_W-1], tan_a}) - $signed({tan_b[TAN_W-1], tan_b});
        diff_next = dsub[TAN_W] ? TAN_W'(-dsub) : dsub[TAN_W-1:0];
        rnd       = {1'b0, prod_reg} + (P_W + 1)'(64'd1 << 23);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= st_a.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_reg    <= st_a.bad || st_b.bad;
        diff_reg  <= diff_next;
        alt_reg   <= alt;
        b2_reg    <= b1_reg;
        plo_reg   <= alt_reg * diff_reg[LO_W-1:0];
        phi_reg   <= alt_reg * diff_reg[TAN_W-1:LO_W];
        b3_reg    <= b2_reg;
        prod_reg  <= (P_W'(phi_reg) << LO_W) + P_W'(plo_reg);
        // saturate and flag when either lane is bad or the rounded value no longer fits the result
        flag_reg  <= b3_reg || (rnd[P_W:56] != '0);
        value_reg <= (b3_reg || (rnd[P_W:56] != '0)) ? '1 : rnd[55:24];
    end

    assign valid = v4_reg;
    assign value = value_reg;
    assign flag  = flag_reg;

endmodule

/* design/camera_ground_footprint.sv */
// Path: a sample taken with start runs through the CORDIC, the divider and the span stages to done;
//   the quotient comes from the divider's 56 bit stages, one bit per stage.
// Throughput: one sample per cycle, every cycle; busy never rises.
// Reset: rst_n clears all valid bits at once and loads the default fields of view.
// The receiver cannot stall: each result is on the ports for exactly the one done cycle.
module camera_ground_footprint #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int TAN_ITERATIONS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [cgf_pkg::ALT_W-1:0]         altitude,
    input  logic signed [15:0]                tilt_x,
    input  logic signed [15:0]                tilt_y,
    output logic                              done,
    output logic [cgf_pkg::OUT_W-1:0]         footprint_width,
    output logic [cgf_pkg::OUT_W-1:0]         footprint_height,
    output logic                              out_of_range,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cgf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);
    import cgf_pkg::*;

    localparam int NIT  = (TAN_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TAN_ITERATIONS;
    // altitude rides alongside the CORDIC and divider stages
    localparam int ADLY = NIT + 1 + DIV_BITS + 2;

    logic [15:0] hfov_reg;
    logic [15:0] vfov_reg;
    logic        accept;

    stat_t                st_c [0:3];
    logic signed [CW-1:0] x_c  [0:3];
    logic signed [CW-1:0] y_c  [0:3];
    stat_t                st_t [0:3];
    logic signed [TAN_W-1:0] tan_t [0:3];

    logic [ALT_W-1:0] alt_reg [0:ADLY-1];

    logic w_valid, h_valid;
    logic w_flag, h_flag;

    // no loop links one sample to the next, so the pipe never pushes back
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // field-of-view registers; writes to unknown indexes drop silently
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hfov_reg <= HFOV_RESET;
            vfov_reg <= VFOV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HFOV: hfov_reg <= cfg_data;
                REG_VFOV: vfov_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    // Edge angles: width pairs tilt_y with the horizontal field of view,
    // height pairs tilt_x with the vertical one. Lane 0/1 = width +/-, 2/3 = height +/-.
    cgf_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TAN_ITERATIONS(TAN_ITERATIONS), .SUM(1'b1))
        u_cor_wp (.clk, .rst_n, .in_valid(accept), .tilt(tilt_y), .fov(hfov_reg),
                  .st(st_c[0]), .x(x_c[0]), .y(y_c[0]));
    cgf_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TAN_ITERATIONS(TAN_ITERATIONS), .SUM(1'b0))
        u_cor_wm (.clk, .rst_n, .in_valid(accept), .tilt(tilt_y), .fov(hfov_reg),
                  .st(st_c[1]), .x(x_c[1]), .y(y_c[1]));
    cgf_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TAN_ITERATIONS(TAN_ITERATIONS), .SUM(1'b1))
        u_cor_hp (.clk, .rst_n, .in_valid(accept), .tilt(tilt_x), .fov(vfov_reg),
                  .st(st_c[2]), .x(x_c[2]), .y(y_c[2]));
    cgf_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .TAN_ITERATIONS(TAN_ITERATIONS), .SUM(1'b0))
        u_cor_hm (.clk, .rst_n, .in_valid(accept), .tilt(tilt_x), .fov(vfov_reg),
                  .st(st_c[3]), .x(x_c[3]), .y(y_c[3]));

    // y/x for each lane; a vanishing or negative cosine marks the lane bad
    for (genvar l = 0; l < 4; l++)
    begin : g_div
        cgf_div u_div (
            .clk,
            .rst_n,
            .st_in  (st_c[l]),
            .x      (x_c[l]),
            .y      (y_c[l]),
            .st_out (st_t[l]),
            .tan    (tan_t[l])
        );
    end

    // delay the altitude to meet the tangents at the span stage
    always_ff @(posedge clk)
    begin
        alt_reg[0] <= altitude;
    end

    for (genvar k = 1; k < ADLY; k++)
    begin : g_alt
        always_ff @(posedge clk)
        begin
            alt_reg[k] <= alt_reg[k-1];
        end
    end

    cgf_span u_span_w (
        .clk,
        .rst_n,
        .st_a  (st_t[0]),
        .st_b  (st_t[1]),
        .tan_a (tan_t[0]),
        .tan_b (tan_t[1]),
        .alt   (alt_reg[ADLY-1]),
        .valid (w_valid),
        .value (footprint_width),
        .flag  (w_flag)
    );

    cgf_span u_span_h (
        .clk,
        .rst_n,
        .st_a  (st_t[2]),
        .st_b  (st_t[3]),
        .tan_a (tan_t[2]),
        .tan_b (tan_t[3]),
        .alt   (alt_reg[ADLY-1]),
        .valid (h_valid),
        .value (footprint_height),
        .flag  (h_flag)
    );

    // both dimensions walk the same stages; advance on the pair together
    assign done         = w_valid && h_valid;
    assign out_of_range = w_flag || h_flag;

endmodule

/* design/cgf_checker.sv */
// Port-level checks for camera_ground_footprint, attached through bind.
// Depends on cgf_pkg for widths and the arctangent table depth; sees the top level's ports only.
module cgf_checker #(
    parameter int TAN_ITERATIONS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [cgf_pkg::ALT_W-1:0]     altitude,
    input logic                          done,
    input logic [cgf_pkg::OUT_W-1:0]     footprint_width,
    input logic [cgf_pkg::OUT_W-1:0]     footprint_height,
    input logic                          out_of_range
);
    import cgf_pkg::*;

    localparam int NIT = (TAN_ITERATIONS > ATAN_LEN) ? ATAN_LEN : TAN_ITERATIONS;
    localparam int LAT = NIT + 63;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted beat produced no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without an accepted beat");

    a_flag_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_of_range) |-> (footprint_width == '1 || footprint_height == '1))
        else $error("flag set without a saturated dimension");

    a_zero_alt: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && altitude == '0) |-> ##LAT
        (out_of_range || (footprint_width == '0 && footprint_height == '0)))
        else $error("zero altitude gave a nonzero footprint");

endmodule

bind camera_ground_footprint cgf_checker #(.TAN_ITERATIONS(TAN_ITERATIONS)) u_cgf_checker (.*);
